[hw/rtl/lfsc_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// lfsc_pkg
// Shared types and constants of the line follower steering controller.
// ---------------------------------------------------------------------------
package lfsc_pkg;

  localparam int HISTORY_DEPTH_DEF = 10;
  localparam int SENSOR_COUNT_DEF  = 8;

  localparam int PAT_W     = 8;
  localparam int POS_W     = 13;
  localparam int CMD_W     = 3;
  localparam int SPEED_W   = 8;
  localparam int HOLD_W    = 11;
  localparam int GAIN_W    = 16;
  localparam int RUNCFG_W  = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  localparam int ERR_W   = 13;
  localparam int DIFF_W  = 14;
  localparam int SUM_W   = 32;
  localparam int MULA_W  = 33;
  localparam int MULB_W  = GAIN_W + 1;
  localparam int PROD_W  = MULA_W + MULB_W;
  localparam int FRAC_W  = 16;
  localparam int CORR_W  = PROD_W - FRAC_W;
  localparam int SPDX_W  = CORR_W + 1;

  localparam logic [POS_W-1:0]  POS_MAX    = 13'd7000;
  localparam logic [POS_W-1:0]  POS_CENTRE = 13'd3500;
  localparam logic [HOLD_W-1:0] HOLD_PULSE = 11'd150;
  localparam logic [HOLD_W-1:0] HOLD_END   = 11'd2000;

  typedef enum logic [CMD_W-1:0] {
    CMD_DRIVE     = 3'd0,
    CMD_FWD       = 3'd1,
    CMD_STOP_HOLD = 3'd2,
    CMD_STOP      = 3'd3,
    CMD_RIGHT     = 3'd4,
    CMD_LEFT      = 3'd5,
    CMD_BACK      = 3'd6
  } motion_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P     = 3'd0,
    REG_GAIN_I     = 3'd1,
    REG_GAIN_D     = 3'd2,
    REG_BASE_SPEED = 3'd3,
    REG_MAX_SPEED  = 3'd4,
    REG_START_RUN  = 3'd5,
    REG_END_RUN    = 3'd6,
    REG_TURN_SPEED = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    MUL_P = 2'd0,
    MUL_I = 2'd1,
    MUL_D = 2'd2
  } mul_sel_t;

  typedef struct packed {
    logic [GAIN_W-1:0]   gain_p;
    logic [GAIN_W-1:0]   gain_i;
    logic [GAIN_W-1:0]   gain_d;
    logic [SPEED_W-1:0]  base_speed;
    logic [SPEED_W-1:0]  max_speed;
    logic [RUNCFG_W-1:0] start_run;
    logic [RUNCFG_W-1:0] end_run;
    logic [SPEED_W-1:0]  turn_speed;
  } cfg_t;

  typedef struct packed {
    logic     load;
    logic     set_started;
    logic     scan_clr;
    logic     scan_inc;
    logic     hit_latch;
    logic     pid_upd;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     acc_add;
    logic     corr_en;
    logic     emit;
    motion_t  emit_cmd;
    logic     emit_last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic    start_hit;
    logic    end_hit;
    logic    pat_zero;
    logic    hit;
    motion_t hit_cmd;
    logic    scan_last;
    logic    out_free;
  } dp_status_t;

endpackage
`default_nettype wire

[hw/rtl/lfsc_ctrl.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// lfsc_ctrl
// Sequencer: walks one sample through decision, history scan and PID steps.
// ---------------------------------------------------------------------------
module lfsc_ctrl
  import lfsc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  dp_status_t      status,
  output ctrl_cmd_t       cmd
);

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_DECIDE = 13'b0000000000010,
    S_SCAN   = 13'b0000000000100,
    S_HIT    = 13'b0000000001000,
    S_BACK   = 13'b0000000010000,
    S_STOP2  = 13'b0000000100000,
    S_PID    = 13'b0000001000000,
    S_MUL0   = 13'b0000010000000,
    S_MUL1   = 13'b0000100000000,
    S_MUL2   = 13'b0001000000000,
    S_ACC    = 13'b0010000000000,
    S_CORR   = 13'b0100000000000,
    S_DRIVE  = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (status.start_hit) begin
          if (status.out_free) begin
            cmd.emit        = 1'b1;
            cmd.emit_cmd    = CMD_FWD;
            cmd.emit_last   = 1'b1;
            cmd.set_started = 1'b1;
            state_nxt       = S_IDLE;
          end
        end else if (status.end_hit) begin
          if (status.out_free) begin
            cmd.emit      = 1'b1;
            cmd.emit_cmd  = CMD_STOP_HOLD;
            cmd.emit_last = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else if (status.pat_zero) begin
          if (status.out_free) begin
            cmd.emit     = 1'b1;
            cmd.emit_cmd = CMD_STOP;
            cmd.scan_clr = 1'b1;
            state_nxt    = S_SCAN;
          end
        end else begin
          state_nxt = S_PID;
        end
      end
      S_SCAN: begin
        if (status.hit) begin
          cmd.hit_latch = 1'b1;
          state_nxt     = S_HIT;
        end else if (status.scan_last) begin
          state_nxt = S_BACK;
        end else begin
          cmd.scan_inc = 1'b1;
        end
      end
      S_HIT: begin
        if (status.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_cmd = status.hit_cmd;
          state_nxt    = S_PID;
        end
      end
      S_BACK: begin
        if (status.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_cmd = CMD_BACK;
          state_nxt    = S_STOP2;
        end
      end
      S_STOP2: begin
        if (status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_cmd  = CMD_STOP;
          cmd.emit_last = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_PID: begin
        cmd.pid_upd = 1'b1;
        state_nxt   = S_MUL0;
      end
      S_MUL0: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_P;
        state_nxt   = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_I;
        cmd.acc_add = 1'b1;
        state_nxt   = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_D;
        cmd.acc_add = 1'b1;
        state_nxt   = S_ACC;
      end
      S_ACC: begin
        cmd.acc_add = 1'b1;
        state_nxt   = S_CORR;
      end
      S_CORR: begin
        cmd.corr_en = 1'b1;
        state_nxt   = S_DRIVE;
      end
      S_DRIVE: begin
        if (status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_cmd  = CMD_DRIVE;
          cmd.emit_last = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[hw/rtl/lfsc_dp.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// lfsc_dp
// Datapath: pattern history, run counter, shape scan, PID and result register.
// ---------------------------------------------------------------------------
module lfsc_dp
  import lfsc_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  parameter int SENSOR_COUNT  = SENSOR_COUNT_DEF
)
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  cfg_t                    cfg,
  input  wire logic [PAT_W-1:0]   in_pattern,
  input  wire logic [POS_W-1:0]   in_position,
  input  ctrl_cmd_t               cmd,
  output dp_status_t              status,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output logic [CMD_W-1:0]        out_command,
  output logic [SPEED_W-1:0]      out_speed_left,
  output logic [SPEED_W-1:0]      out_speed_right,
  output logic [HOLD_W-1:0]       out_hold_ms,
  output logic                    out_last
);

  localparam int SC    = SENSOR_COUNT;
  localparam int RUN_W = $clog2(HISTORY_DEPTH + 1);
  localparam int IDX_W = $clog2(HISTORY_DEPTH);
  localparam int CMP_W = (RUN_W > RUNCFG_W) ? RUN_W : RUNCFG_W;
  localparam int EXT_W = PAT_W + 16;

  localparam logic [SC-1:0]    ALL_ONES  = {SC{1'b1}};
  localparam logic [SC-1:0]    LEFT_LIM  = SC'((32'd1 << (SC - 2)) - 32'd1);
  localparam int unsigned      GAP_MID   = 32'd3 << (SC / 2 - 1);
  localparam logic [SC-1:0]    GAP0      = SC'(GAP_MID);
  localparam logic [SC-1:0]    GAP1      = SC'(GAP_MID << 1);
  localparam logic [SC-1:0]    GAP2      = SC'(GAP_MID >> 1);
  localparam logic [IDX_W-1:0] IDX_FIRST = IDX_W'(1);
  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(HISTORY_DEPTH - 1);
  localparam logic [RUN_W-1:0] RUN_FULL  = RUN_W'(HISTORY_DEPTH);

  function automatic logic is_right(input logic [SC-1:0] p);
    logic [SC-1:0] z;
    logic [SC:0]   zp1;
    begin
      z   = ~p;
      zp1 = {1'b0, z} + {{SC{1'b0}}, 1'b1};
      is_right = (p != '0) && (z >= SC'(3)) && ((zp1 & (zp1 - 1'b1)) == '0);
    end
  endfunction

  function automatic logic is_left(input logic [SC-1:0] p);
    logic [SC:0] pp1;
    begin
      pp1     = {1'b0, p} + {{SC{1'b0}}, 1'b1};
      is_left = (p != '0) && (p <= LEFT_LIM) && ((pp1 & (pp1 - 1'b1)) == '0);
    end
  endfunction

  function automatic logic is_gap(input logic [SC-1:0] p);
    is_gap = (p == GAP0) || (p == GAP1) || (p == GAP2);
  endfunction

  // History, run and flags
  logic [SC-1:0]     hist_r [HISTORY_DEPTH];
  logic [RUN_W-1:0]  run_r;
  logic              started_r;
  logic              pat_zero_r;
  logic [POS_W-1:0]  pos_r;
  logic [IDX_W-1:0]  idx_r;
  motion_t           hit_cmd_r;

  logic [EXT_W-1:0]  pat_ext;
  logic [SC-1:0]     pat;
  logic [SC-1:0]     scan_pat;
  logic              sh_right, sh_left, sh_gap;

  assign pat_ext  = {16'd0, in_pattern};
  assign pat      = pat_ext[SC-1:0];
  assign scan_pat = hist_r[idx_r];
  assign sh_right = is_right(scan_pat);
  assign sh_left  = is_left(scan_pat);
  assign sh_gap   = is_gap(scan_pat);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist_r[i] <= ALL_ONES;
      end
      run_r     <= RUN_FULL;
      started_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        hist_r[0] <= pat;
        for (int i = 1; i < HISTORY_DEPTH; i++) begin
          hist_r[i] <= hist_r[i-1];
        end
        if (pat == ALL_ONES) begin
          run_r <= (run_r == RUN_FULL) ? run_r : run_r + 1'b1;
        end else begin
          run_r <= '0;
        end
      end
      if (cmd.set_started) begin
        started_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pat_zero_r <= (pat == '0);
      pos_r      <= (in_position > POS_MAX) ? POS_MAX : in_position;
    end
    if (cmd.scan_clr) begin
      idx_r <= IDX_FIRST;
    end else if (cmd.scan_inc) begin
      idx_r <= idx_r + 1'b1;
    end
    if (cmd.hit_latch) begin
      if (sh_right) begin
        hit_cmd_r <= CMD_RIGHT;
      end else if (sh_left) begin
        hit_cmd_r <= CMD_LEFT;
      end else begin
        hit_cmd_r <= CMD_FWD;
      end
    end
  end

  // PID
  logic signed [ERR_W-1:0]  err_r, err_new;
  logic signed [ERR_W-1:0]  prev_err_r;
  logic signed [DIFF_W-1:0] diff_r;
  logic signed [SUM_W-1:0]  sum_r, sum_sat;
  logic signed [SUM_W:0]    sum_wide;
  logic signed [DIFF_W-1:0] err_wide;
  logic signed [MULA_W-1:0] mul_a;
  logic signed [MULB_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [PROD_W-1:0] acc_r;
  logic signed [PROD_W-1:0] acc_bias;
  logic signed [CORR_W-1:0] corr_r;

  assign err_wide = $signed({1'b0, POS_CENTRE}) - $signed({1'b0, pos_r});
  assign err_new  = err_wide[ERR_W-1:0];
  assign sum_wide = {sum_r[SUM_W-1], sum_r} + {{(SUM_W+1-ERR_W){err_new[ERR_W-1]}}, err_new};

  always_comb begin
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[SUM_W-1:0];
    end
  end

  always_comb begin
    case (cmd.mul_sel)
      MUL_P: begin
        mul_a = {{(MULA_W-ERR_W){err_r[ERR_W-1]}}, err_r};
        mul_b = $signed({1'b0, cfg.gain_p});
      end
      MUL_I: begin
        mul_a = {sum_r[SUM_W-1], sum_r};
        mul_b = $signed({1'b0, cfg.gain_i});
      end
      MUL_D: begin
        mul_a = {{(MULA_W-DIFF_W){diff_r[DIFF_W-1]}}, diff_r};
        mul_b = $signed({1'b0, cfg.gain_d});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_nxt = mul_a * mul_b;
  end

  // Division by 2^16 rounding toward zero: bias negatives before the shift.
  assign acc_bias = acc_r + (acc_r[PROD_W-1] ? PROD_W'(65535) : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r      <= '0;
      prev_err_r <= '0;
    end else if (cmd.pid_upd) begin
      sum_r      <= sum_sat;
      prev_err_r <= err_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pid_upd) begin
      err_r  <= err_new;
      diff_r <= {err_new[ERR_W-1], err_new} - {prev_err_r[ERR_W-1], prev_err_r};
      acc_r  <= '0;
    end else if (cmd.acc_add) begin
      acc_r <= acc_r + prod_r;
    end
    if (cmd.mul_en) begin
      prod_r <= prod_nxt;
    end
    if (cmd.corr_en) begin
      corr_r <= acc_bias[PROD_W-1:FRAC_W];
    end
  end

  // Motor speeds from the correction, clamped to [0, max_speed]
  logic signed [SPDX_W-1:0] spd_a, spd_b;
  logic signed [SPDX_W-1:0] base_x, max_x;
  logic [SPEED_W-1:0]       sat_a, sat_b;

  assign base_x = $signed({{(SPDX_W-SPEED_W){1'b0}}, cfg.base_speed});
  assign max_x  = $signed({{(SPDX_W-SPEED_W){1'b0}}, cfg.max_speed});
  assign spd_a  = base_x + {corr_r[CORR_W-1], corr_r};
  assign spd_b  = base_x - {corr_r[CORR_W-1], corr_r};

  always_comb begin
    if (spd_a[SPDX_W-1]) begin
      sat_a = '0;
    end else if (spd_a > max_x) begin
      sat_a = cfg.max_speed;
    end else begin
      sat_a = spd_a[SPEED_W-1:0];
    end
    if (spd_b[SPDX_W-1]) begin
      sat_b = '0;
    end else if (spd_b > max_x) begin
      sat_b = cfg.max_speed;
    end else begin
      sat_b = spd_b[SPEED_W-1:0];
    end
  end

  // Result register
  logic               out_valid_r;
  logic [SPEED_W-1:0] left_nxt, right_nxt;
  logic [HOLD_W-1:0]  hold_nxt;

  always_comb begin
    left_nxt  = '0;
    right_nxt = '0;
    hold_nxt  = '0;
    case (cmd.emit_cmd)
      CMD_DRIVE: begin
        left_nxt  = sat_a;
        right_nxt = sat_b;
      end
      CMD_RIGHT, CMD_LEFT: begin
        left_nxt  = cfg.turn_speed;
        right_nxt = cfg.turn_speed;
      end
      CMD_FWD, CMD_BACK: begin
        hold_nxt = HOLD_PULSE;
      end
      CMD_STOP_HOLD: begin
        hold_nxt = HOLD_END;
      end
      default: begin
        hold_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_command     <= cmd.emit_cmd;
      out_speed_left  <= left_nxt;
      out_speed_right <= right_nxt;
      out_hold_ms     <= hold_nxt;
      out_last        <= cmd.emit_last;
    end
  end

  assign out_valid = out_valid_r;

  assign status.start_hit = (CMP_W'(run_r) > CMP_W'(cfg.start_run)) && !started_r;
  assign status.end_hit   = (CMP_W'(run_r) > CMP_W'(cfg.end_run)) && started_r;
  assign status.pat_zero  = pat_zero_r;
  assign status.hit       = sh_right || sh_left || sh_gap;
  assign status.hit_cmd   = hit_cmd_r;
  assign status.scan_last = (idx_r == IDX_LAST);
  assign status.out_free  = !out_valid_r || out_ready;

endmodule
`default_nettype wire

[hw/rtl/line_follower_steering_controller.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// line_follower_steering_controller
// Turns line sensor samples into motion commands and PID motor speeds.
// ---------------------------------------------------------------------------
// Each input beat is one sensor sample and gives one to three result beats,
// the final one marked with out_tlast. The block works on one sample at a
// time. A start or end sample has its result written to the output register
// in the decision state. A plain sample goes on from the decision state to
// the PID update, then runs its three gain products one after another
// through a single shared 33 x 17 multiplier with an accumulator, divides
// the sum by 2^16 into a correction and writes its drive result to the
// output register. An all-zero pattern scans the older history entries one
// per cycle until a shape is found or the oldest entry is reached. A result
// that the sink has not yet taken holds the sequence only when the next
// result is due; the block takes the next sample while the last result of
// the previous one still waits. Configuration writes take effect at once and
// should only be made while the block is idle.
// ---------------------------------------------------------------------------
module line_follower_steering_controller
  import lfsc_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  parameter int SENSOR_COUNT  = SENSOR_COUNT_DEF
)
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // Configuration write port
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data,
  // Sample input
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [23:0]          in_tdata,   // line_pattern[7:0], line_position[20:8]
  // Result output
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [31:0]               out_tdata,  // command[2:0], speed_left[10:3],
                                                // speed_right[18:11], hold_ms[29:19]
  output logic                      out_tlast
);

  // Configuration registers, loaded with their reset defaults.
  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p     <= 16'd4588;
      cfg_r.gain_i     <= 16'd52;
      cfg_r.gain_d     <= 16'd39322;
      cfg_r.base_speed <= 8'd100;
      cfg_r.max_speed  <= 8'd150;
      cfg_r.start_run  <= 4'd5;
      cfg_r.end_run    <= 4'd6;
      cfg_r.turn_speed <= 8'd120;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_GAIN_P:     cfg_r.gain_p     <= cfg_data;
        REG_GAIN_I:     cfg_r.gain_i     <= cfg_data;
        REG_GAIN_D:     cfg_r.gain_d     <= cfg_data;
        REG_BASE_SPEED: cfg_r.base_speed <= cfg_data[SPEED_W-1:0];
        REG_MAX_SPEED:  cfg_r.max_speed  <= cfg_data[SPEED_W-1:0];
        REG_START_RUN:  cfg_r.start_run  <= cfg_data[RUNCFG_W-1:0];
        REG_END_RUN:    cfg_r.end_run    <= cfg_data[RUNCFG_W-1:0];
        REG_TURN_SPEED: cfg_r.turn_speed <= cfg_data[SPEED_W-1:0];
        default: begin
        end
      endcase
    end
  end

  ctrl_cmd_t  cmd;
  dp_status_t status;

  logic [CMD_W-1:0]   res_command;
  logic [SPEED_W-1:0] res_left;
  logic [SPEED_W-1:0] res_right;
  logic [HOLD_W-1:0]  res_hold;

  // The sequencer steps each sample through its decision, scan and PID.
  lfsc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath holds the history, PID state and the output register.
  lfsc_dp #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .SENSOR_COUNT  (SENSOR_COUNT)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .in_pattern      (in_tdata[7:0]),
    .in_position     (in_tdata[20:8]),
    .cmd             (cmd),
    .status          (status),
    .out_ready       (out_tready),
    .out_valid       (out_tvalid),
    .out_command     (res_command),
    .out_speed_left  (res_left),
    .out_speed_right (res_right),
    .out_hold_ms     (res_hold),
    .out_last        (out_tlast)
  );

  assign out_tdata = {2'b00, res_hold, res_right, res_left, res_command};

endmodule
`default_nettype wire

[dv/lfsc_checker.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// lfsc_checker
// Predicts and checks the result beats of the line follower steering
// controller.
// ---------------------------------------------------------------------------
// Follows the configuration writes and the accepted sample beats, keeps its
// own copy of the pattern history, the started flag and the PID state, and
// compares every result beat with the oldest predicted motion beat.
// ---------------------------------------------------------------------------
module lfsc_checker
  import lfsc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [23:0]          in_tdata,
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [31:0]          out_tdata,
  input  logic                 out_tlast,
  output int                   mismatches,
  output int                   outstanding
);

  typedef struct packed {
    motion_t            cmd;
    logic [SPEED_W-1:0] left;
    logic [SPEED_W-1:0] right;
    logic [HOLD_W-1:0]  hold;
    logic               last;
  } motion_beat_t;

  localparam int DEPTH   = HISTORY_DEPTH_DEF;
  localparam int SENSORS = SENSOR_COUNT_DEF;

  localparam logic [PAT_W-1:0] FULL     = PAT_W'((1 << SENSORS) - 1);
  localparam logic [PAT_W-1:0] GAP_MID  = PAT_W'(3 << (SENSORS / 2 - 1));
  localparam logic [PAT_W-1:0] LEFT_TOP = PAT_W'((1 << (SENSORS - 2)) - 1);
  localparam longint SUM_HI = 64'sd2147483647;
  localparam longint SUM_LO = -64'sd2147483648;

  cfg_t             shadow;
  logic [PAT_W-1:0] history [DEPTH];
  logic             started;
  int               err_sum;
  int               prev_err;
  int               fail_tally;
  motion_beat_t     motion_q[$];

  function automatic bit pow2(int unsigned v);
    return v != 0 && (v & (v - 1)) == 0;
  endfunction

  // Ones at the top, between one and SENSORS-2 of them.
  function automatic bit right_turn(logic [PAT_W-1:0] p);
    int unsigned zeros;
    zeros = FULL & ~p;
    return p != 0 && zeros >= 3 && pow2(zeros + 1);
  endfunction

  function automatic bit left_turn(logic [PAT_W-1:0] p);
    return p >= 1 && p <= LEFT_TOP && pow2(int'(p) + 1);
  endfunction

  function automatic bit gap_seen(logic [PAT_W-1:0] p);
    return p == GAP_MID || p == (GAP_MID << 1) || p == (GAP_MID >> 1);
  endfunction

  function automatic motion_beat_t beat_of(motion_t c, logic [SPEED_W-1:0] l,
                                           logic [SPEED_W-1:0] r, logic [HOLD_W-1:0] h);
    return '{cmd: c, left: l, right: r, hold: h, last: 1'b0};
  endfunction

  function automatic string describe(motion_beat_t b);
    return $sformatf("cmd %0d left %0d right %0d hold %0d last %0d",
                     b.cmd, b.left, b.right, b.hold, b.last);
  endfunction

  // One PID step; updates the integral and the previous error.
  function automatic void pid_drive(input logic [POS_W-1:0] pos,
                                    output logic [SPEED_W-1:0] sa,
                                    output logic [SPEED_W-1:0] sb);
    int     err_now;
    int     delta;
    longint total;
    longint acc;
    longint corr;
    longint a;
    longint b;
    err_now = int'(POS_CENTRE) - int'(pos);
    total   = longint'(err_sum) + longint'(err_now);
    if (total > SUM_HI) total = SUM_HI;
    if (total < SUM_LO) total = SUM_LO;
    delta    = err_now - prev_err;
    err_sum  = int'(total);
    prev_err = err_now;
    acc = longint'(err_now) * longint'(shadow.gain_p)
        + longint'(err_sum) * longint'(shadow.gain_i)
        + longint'(delta) * longint'(shadow.gain_d);
    corr = acc / 64'sd65536;
    a = longint'(shadow.base_speed) + corr;
    b = longint'(shadow.base_speed) - corr;
    if (a > longint'(shadow.max_speed)) a = longint'(shadow.max_speed);
    if (b > longint'(shadow.max_speed)) b = longint'(shadow.max_speed);
    if (a < 0) a = 0;
    if (b < 0) b = 0;
    sa = a[SPEED_W-1:0];
    sb = b[SPEED_W-1:0];
  endfunction

  function automatic void forecast(logic [23:0] word);
    logic [PAT_W-1:0]   pat;
    logic [POS_W-1:0]   pos;
    logic [SPEED_W-1:0] sa;
    logic [SPEED_W-1:0] sb;
    int                 run;
    bit                 unbroken;
    bit                 found;
    motion_beat_t       batch[$];
    motion_beat_t       tail;
    pat = word[PAT_W-1:0] & FULL;
    pos = word[PAT_W +: POS_W];
    if (pos > POS_MAX) pos = POS_MAX;
    for (int k = DEPTH - 1; k > 0; k--) history[k] = history[k-1];
    history[0] = pat;
    run      = 0;
    unbroken = 1'b1;
    for (int k = 0; k < DEPTH; k++) begin
      if (history[k] != FULL) unbroken = 1'b0;
      if (unbroken) run++;
    end
    if (run > shadow.start_run && !started) begin
      batch.push_back(beat_of(CMD_FWD, '0, '0, HOLD_PULSE));
      started = 1'b1;
    end else if (run > shadow.end_run && started) begin
      batch.push_back(beat_of(CMD_STOP_HOLD, '0, '0, HOLD_END));
    end else if (pat == 0) begin
      batch.push_back(beat_of(CMD_STOP, '0, '0, '0));
      found = 1'b0;
      // Oldest entries are looked at last; the first shape found wins.
      for (int k = 1; k < DEPTH && !found; k++) begin
        if (right_turn(history[k])) begin
          batch.push_back(beat_of(CMD_RIGHT, shadow.turn_speed, shadow.turn_speed, '0));
          found = 1'b1;
        end else if (left_turn(history[k])) begin
          batch.push_back(beat_of(CMD_LEFT, shadow.turn_speed, shadow.turn_speed, '0));
          found = 1'b1;
        end else if (gap_seen(history[k])) begin
          batch.push_back(beat_of(CMD_FWD, '0, '0, HOLD_PULSE));
          found = 1'b1;
        end
      end
      if (found) begin
        pid_drive(pos, sa, sb);
        batch.push_back(beat_of(CMD_DRIVE, sa, sb, '0));
      end else begin
        // Dead end: reverse briefly and stop, PID state left alone.
        batch.push_back(beat_of(CMD_BACK, '0, '0, HOLD_PULSE));
        batch.push_back(beat_of(CMD_STOP, '0, '0, '0));
      end
    end else begin
      pid_drive(pos, sa, sb);
      batch.push_back(beat_of(CMD_DRIVE, sa, sb, '0));
    end
    tail      = batch.pop_back();
    tail.last = 1'b1;
    batch.push_back(tail);
    foreach (batch[k]) motion_q.push_back(batch[k]);
  endfunction

  always @(posedge clk) begin
    motion_beat_t seen;
    motion_beat_t due;
    if (!rst_n) begin
      shadow = '{gain_p: 16'd4588, gain_i: 16'd52, gain_d: 16'd39322,
                 base_speed: 8'd100, max_speed: 8'd150, start_run: 4'd5,
                 end_run: 4'd6, turn_speed: 8'd120};
      foreach (history[k]) history[k] = FULL;
      started    = 1'b0;
      err_sum    = 0;
      prev_err   = 0;
      fail_tally = 0;
      motion_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        seen = '{cmd: motion_t'(out_tdata[2:0]), left: out_tdata[10:3],
                 right: out_tdata[18:11], hold: out_tdata[29:19], last: out_tlast};
        if (motion_q.size() == 0) begin
          fail_tally++;
          $display("%0t: result beat mismatch: expected none, actual %s",
                   $time, describe(seen));
        end else begin
          due = motion_q.pop_front();
          if (seen !== due) begin
            fail_tally++;
            $display("%0t: result beat mismatch: expected %s, actual %s",
                     $time, describe(due), describe(seen));
          end
        end
      end
      if (in_tvalid && in_tready) forecast(in_tdata);
      if (cfg_wr_en) begin
        case (reg_idx_t'(cfg_index))
          REG_GAIN_P:     shadow.gain_p     = cfg_data;
          REG_GAIN_I:     shadow.gain_i     = cfg_data;
          REG_GAIN_D:     shadow.gain_d     = cfg_data;
          REG_BASE_SPEED: shadow.base_speed = cfg_data[SPEED_W-1:0];
          REG_MAX_SPEED:  shadow.max_speed  = cfg_data[SPEED_W-1:0];
          REG_START_RUN:  shadow.start_run  = cfg_data[RUNCFG_W-1:0];
          REG_END_RUN:    shadow.end_run    = cfg_data[RUNCFG_W-1:0];
          REG_TURN_SPEED: shadow.turn_speed = cfg_data[SPEED_W-1:0];
          default: begin
          end
        endcase
      end
    end
    mismatches  <= fail_tally;
    outstanding <= motion_q.size();
  end

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the line follower steering controller.
// ---------------------------------------------------------------------------
// A short directed sequence walks through start, end, turns, gaps, dead ends
// and out-of-range positions, then several phases of random sensor samples
// run under different register settings, extremes included. Both channels
// idle at random, one phase runs without idling, and once the sink holds off
// for a long stretch so that the block backs up. The checker beside the block
// predicts every result beat.
// ---------------------------------------------------------------------------
module testbench;
  import lfsc_pkg::*;

  // Cycle limit for the whole run, with ample room above the slowest correct run.
  localparam int CYCLE_LIMIT   = 200000;
  // Longer than the longest internal sequence, a history scan followed by the PID.
  localparam int SETTLE_CYCLES = HISTORY_DEPTH_DEF + 15;
  localparam int IDLE_PCT      = 17;
  localparam int CHOKE_CYCLES  = 300;

  localparam logic [PAT_W-1:0] FULL  = '1;
  localparam logic [PAT_W-1:0] EMPTY = '0;
  localparam logic [PAT_W-1:0] GAP_CENTRE = 8'h18;
  localparam logic [PAT_W-1:0] GAP_HIGH   = 8'h30;
  localparam logic [PAT_W-1:0] GAP_LOW    = 8'h0C;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_wr_en;
  reg_idx_t             cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [23:0]          in_tdata;   // line_pattern[7:0], line_position[20:8]
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [31:0]          out_tdata;  // command[2:0], speed_left[10:3],
                                    // speed_right[18:11], hold_ms[29:19]
  logic                 out_tlast;

  logic steady     = 1'b0;  // no idling on either side while set
  logic choke_req  = 1'b0;  // asks the sink for one long hold-off
  logic choke_done = 1'b0;
  int   choke_left = 0;
  int   cycle_count = 0;
  int   offered = 0;
  int   mismatches;
  int   outstanding;

  always #1 clk = ~clk;

  line_follower_steering_controller dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  lfsc_checker steering_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Sink side. The long hold-off is counted here, independently of the
  // sender, which keeps offering samples so that the block fills up.
  always @(posedge clk) begin
    if (choke_left > 0) begin
      out_tready <= 1'b0;
      choke_left <= choke_left - 1;
    end else if (choke_req && !choke_done) begin
      out_tready <= 1'b0;
      choke_left <= CHOKE_CYCLES;
      choke_done <= 1'b1;
    end else begin
      out_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** line_follower_steering_controller: FAILED **");
      $finish;
    end
  end

  // Offers one sample beat, possibly after a few idle cycles, and returns at
  // the edge where it is taken. Valid is left high so that back-to-back beats
  // never lower and raise it within the same step.
  task automatic offer_sample(input logic [PAT_W-1:0] pat, input logic [POS_W-1:0] pos);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, pos, pat};
    do @(posedge clk); while (!in_tready);
    offered++;
  endtask

  // Lets every predicted beat come out, then gives the block time to settle
  // before any register is touched.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_reg(input reg_idx_t idx, input logic [CFG_DAT_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // Writes all eight registers back to back; values wider than a register
  // are deliberately passed through so that masking is exercised too.
  task automatic program_all(input logic [CFG_DAT_W-1:0] gp, gi, gd, base, ceiling,
                             s_run, e_run, turn);
    load_reg(REG_GAIN_P, gp);
    load_reg(REG_GAIN_I, gi);
    load_reg(REG_GAIN_D, gd);
    load_reg(REG_BASE_SPEED, base);
    load_reg(REG_MAX_SPEED, ceiling);
    load_reg(REG_START_RUN, s_run);
    load_reg(REG_END_RUN, e_run);
    load_reg(REG_TURN_SPEED, turn);
    cfg_wr_en <= 1'b0;
  endtask

  // Mostly in range, sometimes near the centre, sometimes past the top.
  function automatic logic [POS_W-1:0] any_position();
    case ($urandom_range(9))
      0:       return POS_W'($urandom_range(8191));
      1:       return POS_W'($urandom_range(3600, 3400));
      default: return POS_W'($urandom_range(7000));
    endcase
  endfunction

  function automatic logic [PAT_W-1:0] turn_shape();
    case ($urandom_range(2))
      0:       return FULL << $urandom_range(7, 2);
      1:       return (8'h01 << $urandom_range(6, 1)) - 8'h01;
      default: begin
        case ($urandom_range(2))
          0:       return GAP_CENTRE;
          1:       return GAP_HIGH;
          default: return GAP_LOW;
        endcase
      end
    endcase
  endfunction

  // Random phase. Most of it is well-formed: runs of all-ones samples, and a
  // turn or gap shape followed by a little noise and then a lost line, so the
  // history search finds something to decide on. The rest is noise.
  task automatic run_random(input int quota);
    int target;
    int kind;
    target = offered + quota;
    while (offered < target) begin
      kind = $urandom_range(99);
      if (kind < 18) begin
        repeat ($urandom_range(10, 1)) offer_sample(FULL, any_position());
      end else if (kind < 55) begin
        offer_sample(turn_shape(), any_position());
        repeat ($urandom_range(2)) offer_sample(PAT_W'($urandom_range(255)), any_position());
        repeat ($urandom_range(2, 1)) offer_sample(EMPTY, any_position());
      end else if (kind < 65) begin
        offer_sample(EMPTY, any_position());
      end else begin
        offer_sample(PAT_W'($urandom_range(255)), any_position());
      end
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = REG_GAIN_P;
    cfg_data  = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, on the reset settings. The history starts full of
    // all-ones patterns, so a lost line straight away is a dead end.
    offer_sample(EMPTY, 13'd0);
    offer_sample(8'hC0, 13'd7000);
    offer_sample(EMPTY, 13'd8191);       // right turn; position saturates
    offer_sample(8'h03, 13'd3500);
    offer_sample(EMPTY, 13'd0);          // left turn
    offer_sample(GAP_CENTRE, 13'd1234);
    offer_sample(EMPTY, 13'd5000);       // gap, forward pulse
    offer_sample(GAP_HIGH, 13'd7001);
    offer_sample(GAP_LOW, 13'd2);
    offer_sample(EMPTY, 13'd6000);
    // Six all-ones samples in a row start the robot, more stop it.
    offer_sample(FULL, 13'd3500);
    offer_sample(FULL, 13'd100);
    offer_sample(FULL, 13'd6900);
    offer_sample(FULL, 13'd3499);
    offer_sample(FULL, 13'd3501);
    offer_sample(FULL, 13'd4000);
    offer_sample(FULL, 13'd2000);
    offer_sample(FULL, 13'd1);
    offer_sample(8'h7F, 13'd4095);
    offer_sample(8'hFE, 13'd0);
    offer_sample(EMPTY, 13'd6999);       // neither pattern is a shape
    offer_sample(8'hFC, 13'd1);
    offer_sample(8'h3F, 13'd8190);
    offer_sample(EMPTY, 13'h1555);
    offer_sample(8'h55, 13'h0AAA);
    offer_sample(8'hAA, 13'h1FFF);

    wait_idle();
    program_all(16'd4588, 16'd52, 16'd39322, 16'd100, 16'd150, 16'd5, 16'd6, 16'd120);
    run_random(65);

    // Everything at its top, with the upper register bits set as well.
    wait_idle();
    program_all('1, '1, '1, '1, '1, '1, '1, '1);
    run_random(55);

    // Everything zero: any all-ones sample now counts as an end.
    wait_idle();
    program_all('0, '0, '0, '0, '0, '0, '0, '0);
    run_random(55);

    // No idling on either side, and one long hold-off by the sink.
    wait_idle();
    program_all(CFG_DAT_W'($urandom_range(65535)), CFG_DAT_W'($urandom_range(2000)),
                CFG_DAT_W'($urandom_range(65535)), CFG_DAT_W'($urandom_range(255)),
                CFG_DAT_W'($urandom_range(255)), CFG_DAT_W'($urandom_range(10)),
                CFG_DAT_W'($urandom_range(10)), CFG_DAT_W'($urandom_range(255)));
    steady    <= 1'b1;
    choke_req <= 1'b1;
    run_random(70);
    steady <= 1'b0;

    wait_idle();
    program_all(CFG_DAT_W'($urandom_range(65535)), CFG_DAT_W'($urandom_range(65535)),
                CFG_DAT_W'($urandom_range(65535)), CFG_DAT_W'($urandom_range(65535)),
                CFG_DAT_W'($urandom_range(65535)), CFG_DAT_W'($urandom_range(65535)),
                CFG_DAT_W'($urandom_range(65535)), CFG_DAT_W'($urandom_range(65535)));
    run_random(75);

    wait_idle();
    program_all(16'd20000, 16'd300, 16'd30000, 16'd128, 16'd200,
                CFG_DAT_W'($urandom_range(10)), CFG_DAT_W'($urandom_range(10)), 16'd1);
    run_random(75);

    wait_idle();
    if (mismatches == 0) begin
      $display("** line_follower_steering_controller: PASSED **");
    end else begin
      $display("** line_follower_steering_controller: FAILED **");
    end
    $finish;
  end

endmodule
